// ----- hw/rtl/tib_pkg.sv -----
// Shared types and constants of the tf-idf index builder.
package tib_pkg;

    localparam int WORDS_DEF      = 512;
    localparam int DOCS_DEF       = 64;
    localparam int COUNT_BITS_DEF = 10;
    localparam int QUEUE_DEPTH    = 2;

    localparam int WORD_IN_W = 9;
    localparam int DOC_IN_W  = 6;
    localparam int CFG_W     = 10;
    localparam int TC_W      = 10;
    localparam int IDF_W     = 15;
    localparam int TFIDF_W   = 25;
    localparam int SEEN_W    = 7;
    localparam int STATUS_W  = 2;

    localparam logic [CFG_W-1:0] WIU_RESET = 10'd512;
    localparam logic [27:0]      LN2_Q28   = 28'd186065279;

    localparam logic REQ_FEATURE = 1'b0;
    localparam logic REQ_READ    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_WORD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_DOC   = 2'd2;

    typedef struct packed {
        logic                 req_type;
        logic [WORD_IN_W-1:0] word;
        logic                 last_of_image;
        logic [DOC_IN_W-1:0]  doc;
        logic                 bad_word;
    } item_t;

endpackage

// ----- hw/rtl/tib_front.sv -----
// Front end: vocabulary register, word range check and a short item queue.
module tib_front #(
    parameter int WORDS = tib_pkg::WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tib_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [tib_pkg::WORD_IN_W-1:0] s_word,
    input  logic                          s_last_of_image,
    input  logic [tib_pkg::DOC_IN_W-1:0]  s_doc,
    input  logic                          accept_en,
    output logic                          q_valid,
    input  logic                          q_ready,
    output tib_pkg::item_t                q_item
);
    import tib_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CFG_W-1:0] wiu_reg;
    item_t            q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      limit;
    logic             push, pop;
    item_t            in_item;

    assign limit = (32'(wiu_reg) < 32'(WORDS)) ? 32'(wiu_reg) : 32'(WORDS);

    always_comb begin
        in_item.req_type      = s_req_type;
        in_item.word          = s_word;
        in_item.last_of_image = s_last_of_image;
        in_item.doc           = s_doc;
        in_item.bad_word      = 32'(s_word) >= limit;
    end

    assign s_ready = accept_en && (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = cnt_reg != '0;
    assign q_item  = q_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wiu_reg    <= WIU_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (cfg_we) begin
                wiu_reg <= cfg_wdata;
            end
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/tib_log2.sv -----
// Iterative log2 unit: integer part by bit search, 32 fraction bits by squaring.
module tib_log2 #(
    parameter int N_W = 7
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] n,
    output logic           done,
    output logic [N_W+31:0] result
);
    import tib_pkg::*;

    logic [N_W-1:0] k, k_reg;
    logic [30:0]    y_reg, y_init, y_nx;
    logic [31:0]    frac_reg;
    logic [4:0]     it_reg;
    logic           run_reg;
    logic [61:0]    sq;
    logic [31:0]    t;
    logic           fbit;

    always_comb begin
        k = '0;
        for (int i = 0; i < N_W; i++) begin
            if (n[i]) begin
                k = N_W'(i);
            end
        end
    end

    assign y_init = 31'({n, 30'b0} >> k);
    assign sq     = 62'(y_reg) * 62'(y_reg);
    assign t      = sq[61:30];
    assign fbit   = t[31];
    assign y_nx   = fbit ? t[31:1] : t[30:0];
    assign done   = run_reg && (it_reg == 5'd31);
    assign result = {k_reg, frac_reg[30:0], fbit};

    always_ff @(posedge aclk) begin
        if (start) begin
            k_reg    <= k;
            y_reg    <= y_init;
            frac_reg <= '0;
        end else if (run_reg) begin
            y_reg    <= y_nx;
            frac_reg <= {frac_reg[30:0], fbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            it_reg  <= '0;
        end else if (start) begin
            run_reg <= 1'b1;
            it_reg  <= '0;
        end else if (run_reg) begin
            it_reg <= it_reg + 1'b1;
            if (done) begin
                run_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/tib_back.sv -----
// Back end: count and frequency tables, document counter, idf and tf-idf datapath.
module tib_back #(
    parameter int WORDS      = tib_pkg::WORDS_DEF,
    parameter int DOCS       = tib_pkg::DOCS_DEF,
    parameter int COUNT_BITS = tib_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  tib_pkg::item_t                q_item,
    output logic                          accept_en,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tib_pkg::TC_W-1:0]      m_term_count,
    output logic [tib_pkg::IDF_W-1:0]     m_idf,
    output logic [tib_pkg::TFIDF_W-1:0]   m_tf_idf,
    output logic [tib_pkg::SEEN_W-1:0]    m_docs_seen,
    output logic [tib_pkg::STATUS_W-1:0]  m_status
);
    import tib_pkg::*;

    localparam int TOTAL  = DOCS * WORDS;
    localparam int TA_W   = $clog2(TOTAL);
    localparam int WORD_W = $clog2(WORDS);
    localparam int DF_W   = $clog2(DOCS + 1);
    localparam int LOG_W  = DF_W + 32;
    localparam int SUM_W  = DF_W + 30;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FWR   = 4'd2;
    localparam logic [3:0] S_RWAIT = 4'd3;
    localparam logic [3:0] S_LA    = 4'd4;
    localparam logic [3:0] S_LB    = 4'd5;
    localparam logic [3:0] S_M1    = 4'd6;
    localparam logic [3:0] S_M2    = 4'd7;
    localparam logic [3:0] S_M3    = 4'd8;
    localparam logic [3:0] S_TF    = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [COUNT_BITS-1:0] tt_mem [TOTAL];
    logic [DF_W-1:0]       df_mem [WORDS];

    logic [3:0]            state_reg;
    logic [TA_W-1:0]       clr_reg;
    logic [DF_W-1:0]       cnt_reg;
    logic [1:0]            flags_reg;
    item_t                 cur_reg;
    logic [TA_W-1:0]       waddr_reg;
    logic [WORD_W-1:0]     wword_reg;
    logic                  zero_reg;
    logic [COUNT_BITS-1:0] tt_q_reg, tc_reg;
    logic [DF_W-1:0]       df_q_reg, df_reg;
    logic [LOG_W-1:0]      la_reg, d_reg;
    logic [59:0]           plo_reg;
    logic [DF_W+27:0]      phi_reg;
    logic [IDF_W-1:0]      idf_reg;
    logic [TFIDF_W-1:0]    tfidf_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [31:0]           row32, addr32;
    logic [TA_W-1:0]       tt_raddr, tt_waddr;
    logic [WORD_W-1:0]     df_raddr, df_waddr;
    logic                  tt_we, df_we;
    logic [COUNT_BITS-1:0] tt_wdata;
    logic [DF_W-1:0]       df_wdata;
    logic                  log_start, log_done;
    logic [DF_W-1:0]       log_n;
    logic [LOG_W-1:0]      log_res;
    logic                  unloaded;
    logic [60:0]           rnd;
    logic [SUM_W-1:0]      sum;
    logic [COUNT_BITS+IDF_W-1:0] prod;

    // Read address: feature words go to the open document's row
    assign row32    = (q_item.req_type == REQ_READ) ? 32'(q_item.doc) : 32'(cnt_reg);
    assign addr32   = row32 * 32'(WORDS) + 32'(q_item.word);
    assign tt_raddr = addr32[TA_W-1:0];
    assign df_raddr = WORD_W'(q_item.word);
    assign unloaded = 32'(q_item.doc) >= 32'(cnt_reg);

    assign tt_we    = (state_reg == S_CLEAR) || (state_reg == S_FWR && tt_q_reg != CMAX);
    assign tt_waddr = (state_reg == S_CLEAR) ? clr_reg : waddr_reg;
    assign tt_wdata = (state_reg == S_CLEAR) ? '0 : tt_q_reg + 1'b1;
    assign df_we    = (state_reg == S_CLEAR && 32'(clr_reg) < 32'(WORDS))
                   || (state_reg == S_FWR && tt_q_reg == '0);
    assign df_waddr = (state_reg == S_CLEAR) ? clr_reg[WORD_W-1:0] : wword_reg;
    assign df_wdata = (state_reg == S_CLEAR) ? '0 : df_q_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (tt_we) begin
            tt_mem[tt_waddr] <= tt_wdata;
        end
        tt_q_reg <= tt_mem[tt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (df_we) begin
            df_mem[df_waddr] <= df_wdata;
        end
        df_q_reg <= df_mem[df_raddr];
    end

    assign log_start = (state_reg == S_RWAIT && !zero_reg && df_q_reg != '0
                        && df_q_reg < cnt_reg)
                    || (state_reg == S_LA && log_done);
    assign log_n     = (state_reg == S_LA) ? df_reg : cnt_reg;

    tib_log2 #(.N_W(DF_W)) u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .n       (log_n),
        .done    (log_done),
        .result  (log_res)
    );

    // ln = d * ln2, split at bit 32 of d; round at bit 47 of the product
    assign rnd  = 61'(plo_reg) + (61'(1) << 47);
    assign sum  = SUM_W'(phi_reg) + SUM_W'(rnd[60:32]);
    assign prod = (COUNT_BITS+IDF_W)'(tc_reg) * (COUNT_BITS+IDF_W)'(idf_reg);

    assign q_ready      = (state_reg == S_IDLE);
    assign accept_en    = (state_reg != S_CLEAR);
    assign m_valid      = (state_reg == S_OUT);
    assign m_term_count = TC_W'(tc_reg);
    assign m_idf        = idf_reg;
    assign m_tf_idf     = tfidf_reg;
    assign m_docs_seen  = SEEN_W'(cnt_reg);
    assign m_status     = status_reg;

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                cur_reg   <= q_item;
                waddr_reg <= tt_raddr;
                wword_reg <= df_raddr;
                zero_reg  <= unloaded || q_item.bad_word;
                if (unloaded || flags_reg[1]) begin
                    status_reg <= ST_NO_DOC;
                end else if (q_item.bad_word || flags_reg[0]) begin
                    status_reg <= ST_BAD_WORD;
                end else begin
                    status_reg <= ST_OK;
                end
            end
            S_RWAIT: begin
                tc_reg <= zero_reg ? '0 : tt_q_reg;
                df_reg <= df_q_reg;
                if (!log_start) begin
                    idf_reg <= '0;
                end
            end
            S_LA: begin
                if (log_done) begin
                    la_reg <= log_res;
                end
            end
            S_LB: begin
                if (log_done) begin
                    d_reg <= la_reg - log_res;
                end
            end
            S_M1: plo_reg <= d_reg[31:0] * LN2_Q28;
            S_M2: phi_reg <= d_reg[LOG_W-1:32] * LN2_Q28;
            S_M3: idf_reg <= IDF_W'(sum >> 16);
            S_TF: tfidf_reg <= TFIDF_W'(prod);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            flags_reg <= '0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == TA_W'(TOTAL - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (q_valid) begin
                        if (q_item.req_type == REQ_READ) begin
                            state_reg <= S_RWAIT;
                        end else if (cnt_reg == DF_W'(DOCS)) begin
                            flags_reg[1] <= 1'b1;
                        end else if (q_item.bad_word) begin
                            flags_reg[0] <= 1'b1;
                            if (q_item.last_of_image) begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end else begin
                            state_reg <= S_FWR;
                        end
                    end
                end
                S_FWR: begin
                    if (cur_reg.last_of_image) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                S_RWAIT: state_reg <= log_start ? S_LA : S_TF;
                S_LA:    if (log_done) state_reg <= S_LB;
                S_LB:    if (log_done) state_reg <= S_M1;
                S_M1:    state_reg <= S_M2;
                S_M2:    state_reg <= S_M3;
                S_M3:    state_reg <= S_TF;
                S_TF:    state_reg <= S_OUT;
                S_OUT:   if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/tfidf_index_builder.sv -----
// Top level of the tf-idf index builder: front queue, table back end.
// After reset the block sweeps its count table once, DOCS*WORDS entries (32768 by
// default), with s_ready low; cfg writes are taken during the sweep. A feature
// word is then a read-modify-write of the count and frequency tables in the back
// end. A read request with nonzero idf runs the log2 unit, which produces one
// fraction bit per cycle, for the document count and the document frequency in
// turn, then the split ln2 multiply; reads that give idf zero skip both. A
// two-entry queue lets the input take items while a result waits on m_ready.
module tfidf_index_builder #(
    parameter int WORDS      = tib_pkg::WORDS_DEF,
    parameter int DOCS       = tib_pkg::DOCS_DEF,
    parameter int COUNT_BITS = tib_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tib_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [tib_pkg::WORD_IN_W-1:0] s_word,
    input  logic                          s_last_of_image,
    input  logic [tib_pkg::DOC_IN_W-1:0]  s_doc,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tib_pkg::TC_W-1:0]      m_term_count,
    output logic [tib_pkg::IDF_W-1:0]     m_idf,
    output logic [tib_pkg::TFIDF_W-1:0]   m_tf_idf,
    output logic [tib_pkg::SEEN_W-1:0]    m_docs_seen,
    output logic [tib_pkg::STATUS_W-1:0]  m_status
);
    import tib_pkg::*;

    item_t q_item;
    logic  q_valid, q_ready, accept_en;

    tib_front #(.WORDS(WORDS)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_word          (s_word),
        .s_last_of_image (s_last_of_image),
        .s_doc           (s_doc),
        .accept_en       (accept_en),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item)
    );

    tib_back #(.WORDS(WORDS), .DOCS(DOCS), .COUNT_BITS(COUNT_BITS)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .accept_en    (accept_en),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_term_count (m_term_count),
        .m_idf        (m_idf),
        .m_tf_idf     (m_tf_idf),
        .m_docs_seen  (m_docs_seen),
        .m_status     (m_status)
    );

endmodule

// ----- hw/rtl/tib_checker.sv -----
// Port-level checks of the tf-idf index builder and their binding.
module tib_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [tib_pkg::TC_W-1:0]      m_term_count,
    input logic [tib_pkg::IDF_W-1:0]     m_idf,
    input logic [tib_pkg::TFIDF_W-1:0]   m_tf_idf,
    input logic [tib_pkg::SEEN_W-1:0]    m_docs_seen,
    input logic [tib_pkg::STATUS_W-1:0]  m_status
);
    import tib_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid && !s_ready)
        else $error("outputs active right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tf_idf) && $stable(m_status))
        else $error("stalled item changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_BAD_WORD || m_status == ST_NO_DOC))
        else $error("undefined status code");

    a_zero_tc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_term_count == '0 || m_idf == '0) |-> m_tf_idf == '0)
        else $error("tf_idf nonzero with a zero factor");

    a_no_doc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_NO_DOC && m_docs_seen == '0 |-> m_term_count == '0)
        else $error("count from an unloaded document");

endmodule

bind tfidf_index_builder tib_checker u_tib_checker (.*);
